// ----- src/cfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame deframer package
// Shared types, constants and the byte-wide CRC-32 update used by the
// deframer and its register block.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // Frame layout.
    localparam int HEADER_BYTES  = 32;
    localparam int HDR_IDX_W     = $clog2(HEADER_BYTES);
    localparam int PREFIX_BYTES  = 4;
    localparam int TRAILER_BYTES = 4;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Reflected CRC-32.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // End-of-frame status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_BAD_CRC   = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_BAD_VER   = 3'd4;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER
    } cfd_phase_t;

    // One input transfer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } cfd_item_t;

    // One result transfer.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  msg_type;
        logic [7:0]  flag_bits;
        logic [15:0] tlv_count;
        logic [63:0] source_node;
        logic [63:0] send_time_ms;
        logic [31:0] sequence_number;
        logic [31:0] correlation;
        logic [15:0] payload_len;
    } cfd_result_t;

    // Configuration register values.
    typedef struct packed {
        logic [15:0] max_body_len;
        logic [7:0]  expected_version;
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;
    } cfd_cfg_t;

    // One byte through the reflected CRC-32, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ----- src/cfd_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame deframer register block
// APB-style configuration registers: maximum body length, expected version
// and the two magic bytes. Writes complete in the access cycle.
// ----------------------------------------------------------------------------
module cfd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cfd_pkg::DATA_W-1:0]  pwdata,
    output logic [cfd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output cfd_pkg::cfd_cfg_t           cfg
);
    import cfd_pkg::*;

    // Register indexes within the address map.
    localparam logic [1:0] REG_MAX_BODY_LEN = 2'd0;
    localparam logic [1:0] REG_EXP_VERSION  = 2'd1;
    localparam logic [1:0] REG_MAGIC_FIRST  = 2'd2;
    localparam logic [1:0] REG_MAGIC_SECOND = 2'd3;

    cfd_cfg_t   cfg_reg;
    cfd_cfg_t   cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAX_BODY_LEN: cfg_next.max_body_len     = pwdata[15:0];
                REG_EXP_VERSION:  cfg_next.expected_version = pwdata[7:0];
                REG_MAGIC_FIRST:  cfg_next.magic_first      = pwdata[7:0];
                REG_MAGIC_SECOND: cfg_next.magic_second     = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_body_len     <= 16'd4096;
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.magic_first      <= 8'd83;
            cfg_reg.magic_second     <= 8'd78;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_idx)
            REG_MAX_BODY_LEN: prdata = {16'd0, cfg_reg.max_body_len};
            REG_EXP_VERSION:  prdata = {24'd0, cfg_reg.expected_version};
            REG_MAGIC_FIRST:  prdata = {24'd0, cfg_reg.magic_first};
            REG_MAGIC_SECOND: prdata = {24'd0, cfg_reg.magic_second};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- src/crc32_frame_deframer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame deframer
// Parses length-prefixed frames from a byte stream, forwards payload bytes
// and reports one status transfer per unbroken frame with the decoded header.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and gives at most one result per byte.
// An accepted byte lands in an input register and is parsed from there
// (byte-wide CRC-32 update, counter compare, header capture) once the output
// register is free; its result, if any, is then written into the output
// register, which drives the result port. The block sustains one byte
// per cycle while the result side does not stall; while a result waits under
// a stall, the input stalls too. A bad length prefix is reported as soon as
// its fourth byte is parsed; any other unbroken frame ends with a status
// transfer after its last trailer byte.
// ----------------------------------------------------------------------------
module crc32_frame_deframer_top #(
    parameter int BODY_COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  cfd_pkg::cfd_item_t          item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output cfd_pkg::cfd_result_t        result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cfd_pkg::DATA_W-1:0]  pwdata,
    output logic [cfd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import cfd_pkg::*;

    localparam int CW    = BODY_COUNT_BITS;
    localparam int CMP_W = 33;

    cfd_cfg_t    cfg;

    // Input stage.
    logic        item_valid_reg;
    logic        item_valid_next;
    cfd_item_t   item_reg;
    logic        take_item;
    logic        go;

    // Parser state.
    cfd_phase_t  phase_reg;
    cfd_phase_t  phase_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] cnt_eff;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_upd;
    logic [23:0] prefix_reg;
    logic [23:0] prefix_next;
    logic [31:0] body_len;
    logic        len_bad;
    logic [23:0] trailer_reg;
    logic [23:0] trailer_next;
    logic [15:0] plen_reg;
    logic [15:0] plen_next;
    logic [7:0]  header_reg [HEADER_BYTES];
    logic        hdr_we;
    logic [7:0]  b;
    cfd_phase_t  ph_eff;

    // Output stage.
    logic        result_valid_reg;
    logic        result_valid_next;
    cfd_result_t result_reg;
    cfd_result_t res;
    logic        res_hit;

    cfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the parsed byte moves on when the output register is free.
    assign go         = item_valid_reg & (~result_valid_reg | ~result_stall);
    assign item_stall = item_valid_reg & ~go;
    assign take_item  = item_valid & ~item_stall;

    assign item_valid_next   = take_item | (item_valid_reg & ~go);
    assign result_valid_next = (go & res_hit) | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_reg <= item;
        end
        if (go & res_hit)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Restart forces the byte into the first prefix position.
    assign b        = item_reg.data_byte;
    assign ph_eff   = item_reg.restart ? PH_PREFIX : phase_reg;
    assign cnt_eff  = item_reg.restart ? '0 : count_reg;
    assign crc_upd  = crc32_byte(crc_reg, b);
    assign body_len = {prefix_reg, b};
    assign len_bad  = (body_len < 32'(HEADER_BYTES))
                   || (body_len > {16'd0, cfg.max_body_len})
                   || ((body_len >> CW) != 32'd0);

    // Next state and result for the byte in the input register.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        prefix_next  = prefix_reg;
        trailer_next = trailer_reg;
        plen_next    = plen_reg;
        hdr_we       = 1'b0;
        res_hit      = 1'b0;
        res          = '0;
        if (go)
        begin
            phase_next = ph_eff;
            count_next = cnt_eff + 1'b1;
            crc_next   = item_reg.restart ? CRC_INIT : crc_reg;
            unique case (ph_eff)
                PH_PREFIX:
                begin
                    prefix_next = {prefix_reg[15:0], b};
                    if (cnt_eff == CW'(PREFIX_BYTES - 1))
                    begin
                        count_next = '0;
                        if (len_bad)
                        begin
                            res_hit    = 1'b1;
                            res.kind   = KIND_STATUS;
                            res.status = ST_BAD_LEN;
                        end
                        else
                        begin
                            crc_next   = CRC_INIT;
                            plen_next  = 16'(body_len - 32'(HEADER_BYTES));
                            phase_next = PH_HEADER;
                        end
                    end
                end
                PH_HEADER:
                begin
                    hdr_we   = 1'b1;
                    crc_next = crc_upd;
                    if (cnt_eff == CW'(HEADER_BYTES - 1))
                    begin
                        count_next = '0;
                        phase_next = (plen_reg == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next = crc_upd;
                    if ((CMP_W'(cnt_eff) + 1'b1) == CMP_W'(plen_reg))
                    begin
                        count_next = '0;
                        phase_next = PH_TRAILER;
                    end
                    res_hit          = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = b;
                end
                PH_TRAILER:
                begin
                    trailer_next = {trailer_reg[15:0], b};
                    if (cnt_eff == CW'(TRAILER_BYTES - 1))
                    begin
                        count_next      = '0;
                        phase_next      = PH_PREFIX;
                        res_hit         = 1'b1;
                        res.kind        = KIND_STATUS;
                        res.payload_len = plen_reg;
                        if (~crc_reg != {trailer_reg, b})
                        begin
                            // Header is not trusted: its fields stay zero.
                            res.status = ST_BAD_CRC;
                        end
                        else
                        begin
                            if (header_reg[0] != cfg.magic_first
                                || header_reg[1] != cfg.magic_second)
                            begin
                                res.status = ST_BAD_MAGIC;
                            end
                            else if (header_reg[2] != cfg.expected_version)
                            begin
                                res.status = ST_BAD_VER;
                            end
                            else
                            begin
                                res.status = ST_OK;
                            end
                            res.msg_type        = header_reg[3];
                            res.flag_bits       = header_reg[4];
                            res.tlv_count       = {header_reg[6], header_reg[7]};
                            res.source_node     = {header_reg[8],  header_reg[9],
                                                   header_reg[10], header_reg[11],
                                                   header_reg[12], header_reg[13],
                                                   header_reg[14], header_reg[15]};
                            res.send_time_ms    = {header_reg[16], header_reg[17],
                                                   header_reg[18], header_reg[19],
                                                   header_reg[20], header_reg[21],
                                                   header_reg[22], header_reg[23]};
                            res.sequence_number = {header_reg[24], header_reg[25],
                                                   header_reg[26], header_reg[27]};
                            res.correlation     = {header_reg[28], header_reg[29],
                                                   header_reg[30], header_reg[31]};
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_PREFIX;
                end
            endcase
        end
    end

    // Parser control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // Frame data registers; the prefix and trailer shift in one byte at a time.
    always_ff @(posedge clk)
    begin
        prefix_reg  <= prefix_next;
        trailer_reg <= trailer_next;
        plen_reg    <= plen_next;
        if (hdr_we)
        begin
            header_reg[cnt_eff[HDR_IDX_W-1:0]] <= b;
        end
    end

    // The byte counter stays inside the bounds of its phase.
    a_prefix_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PREFIX) |-> (count_reg < CW'(PREFIX_BYTES)))
        else $error("prefix byte counter out of range");

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (count_reg < CW'(HEADER_BYTES)))
        else $error("header byte counter out of range");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (CMP_W'(count_reg) < CMP_W'(plen_reg)))
        else $error("payload counter passed the payload length");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (item_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled without a blocked result");

    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_PAYLOAD) |-> (result.status == ST_OK))
        else $error("payload transfer carries a nonzero status");

endmodule

// ----- tb/crc32_frame_deframer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame deframer testbench
// Feeds byte streams of length-prefixed frames (good frames, corrupted CRC,
// magic and version, bad length prefixes, restarts and noise) through the
// block under several register settings. An in-bench parser predicts every
// payload byte and end-of-frame status; each result transfer is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module crc32_frame_deframer_top_tb;
    import cfd_pkg::*;

    // One byte through the reflected CRC-32, taken bit by bit from the LSB.
    function automatic logic [31:0] crc32_advance(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            c = (c[0] ^ b[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Frame parser mirror and the queue of results it predicts.
    class deframe_checker;
        cfd_cfg_t    cfg;
        cfd_phase_t  phase;
        logic [15:0] byte_count;
        logic [31:0] length_prefix;
        logic [31:0] running_crc;
        logic [31:0] trailer_word;
        logic [7:0]  header_bytes [HEADER_BYTES];
        cfd_result_t pending_results [$];
        int          mismatch_count;

        function new();
            cfg.max_body_len     = 16'd4096;
            cfg.expected_version = 8'd1;
            cfg.magic_first      = 8'd83;
            cfg.magic_second     = 8'd78;
            phase                = PH_PREFIX;
            byte_count           = '0;
            length_prefix        = '0;
            running_crc          = CRC_INIT;
            trailer_word         = '0;
            mismatch_count       = 0;
        endfunction

        function void set_register(int idx, logic [31:0] value);
            case (idx)
                0: cfg.max_body_len = value[15:0];
                1: cfg.expected_version = value[7:0];
                2: cfg.magic_first = value[7:0];
                3: cfg.magic_second = value[7:0];
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        // Big-endian field gathered from the captured header.
        function logic [63:0] header_be(int first, int count);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < count; i++)
                v = {v[55:0], header_bytes[first + i]};
            return v;
        endfunction

        // Advance the parser by one accepted byte and queue any result it causes.
        function void accept_byte(cfd_item_t it);
            cfd_result_t r;
            logic [7:0]  b;
            b = it.data_byte;
            r = '0;
            if (it.restart)
            begin
                phase         = PH_PREFIX;
                byte_count    = '0;
                length_prefix = '0;
                running_crc   = CRC_INIT;
            end
            case (phase)
                PH_PREFIX:
                begin
                    length_prefix = {length_prefix[23:0], b};
                    byte_count++;
                    if (byte_count >= PREFIX_BYTES)
                    begin
                        byte_count = '0;
                        // The register is 16 bits, so it also bounds the body counter.
                        if (length_prefix < HEADER_BYTES || length_prefix > cfg.max_body_len)
                        begin
                            length_prefix = '0;
                            r.kind        = KIND_STATUS;
                            r.status      = ST_BAD_LEN;
                            pending_results.push_back(r);
                        end
                        else
                        begin
                            running_crc = CRC_INIT;
                            phase       = PH_HEADER;
                        end
                    end
                end
                PH_HEADER:
                begin
                    header_bytes[byte_count[HDR_IDX_W-1:0]] = b;
                    running_crc = crc32_advance(running_crc, b);
                    byte_count++;
                    if (byte_count >= HEADER_BYTES)
                    begin
                        byte_count = '0;
                        phase = (length_prefix == HEADER_BYTES) ? PH_TRAILER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    running_crc = crc32_advance(running_crc, b);
                    byte_count++;
                    if (byte_count >= length_prefix - HEADER_BYTES)
                    begin
                        byte_count = '0;
                        phase      = PH_TRAILER;
                    end
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = b;
                    pending_results.push_back(r);
                end
                default:
                begin
                    trailer_word = {trailer_word[23:0], b};
                    byte_count++;
                    if (byte_count >= TRAILER_BYTES)
                    begin
                        byte_count    = '0;
                        phase         = PH_PREFIX;
                        r.kind        = KIND_STATUS;
                        r.payload_len = 16'(length_prefix - HEADER_BYTES);
                        length_prefix = '0;
                        // A failed CRC leaves the header untrusted, so its fields stay zero.
                        if ((running_crc ^ CRC_INIT) != trailer_word)
                            r.status = ST_BAD_CRC;
                        else
                        begin
                            if (header_bytes[0] != cfg.magic_first ||
                                header_bytes[1] != cfg.magic_second)
                                r.status = ST_BAD_MAGIC;
                            else if (header_bytes[2] != cfg.expected_version)
                                r.status = ST_BAD_VER;
                            else
                                r.status = ST_OK;
                            r.msg_type        = header_bytes[3];
                            r.flag_bits       = header_bytes[4];
                            r.tlv_count       = 16'(header_be(6, 2));
                            r.source_node     = header_be(8, 8);
                            r.send_time_ms    = header_be(16, 8);
                            r.sequence_number = 32'(header_be(24, 4));
                            r.correlation     = 32'(header_be(28, 4));
                        end
                        pending_results.push_back(r);
                    end
                end
            endcase
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void match_result(cfd_result_t got);
            cfd_result_t want;
            string       diff;
            if (pending_results.size() == 0)
            begin
                flag($sformatf("result %h arrived with nothing pending", got));
                return;
            end
            want = pending_results.pop_front();
            diff = "";
            if (got.kind !== want.kind) diff = {diff, " kind"};
            if (got.payload_byte !== want.payload_byte) diff = {diff, " payload_byte"};
            if (got.status !== want.status) diff = {diff, " status"};
            if (got.msg_type !== want.msg_type) diff = {diff, " msg_type"};
            if (got.flag_bits !== want.flag_bits) diff = {diff, " flag_bits"};
            if (got.tlv_count !== want.tlv_count) diff = {diff, " tlv_count"};
            if (got.source_node !== want.source_node) diff = {diff, " source_node"};
            if (got.send_time_ms !== want.send_time_ms) diff = {diff, " send_time_ms"};
            if (got.sequence_number !== want.sequence_number)
                diff = {diff, " sequence_number"};
            if (got.correlation !== want.correlation) diff = {diff, " correlation"};
            if (got.payload_len !== want.payload_len) diff = {diff, " payload_len"};
            if (diff != "")
                flag($sformatf("fields differ:%s; expected %h, got %h", diff, want, got));
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 8;

    // Register indexes.
    localparam int REG_MAX_BODY_LEN     = 0;
    localparam int REG_EXPECTED_VERSION = 1;
    localparam int REG_MAGIC_FIRST      = 2;
    localparam int REG_MAGIC_SECOND     = 3;

    // How frame bytes are filled.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // Which magic bytes are corrupted.
    localparam int MAGIC_OK         = 0;
    localparam int MAGIC_BAD_FIRST  = 1;
    localparam int MAGIC_BAD_SECOND = 2;
    localparam int MAGIC_BAD_BOTH   = 3;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    cfd_item_t            item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    cfd_result_t          result;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    deframe_checker       sb = new();
    cfd_item_t            stream_q [$];
    logic                 restart_next = 1'b0;
    int                   items_sent = 0;
    int                   burst_left = 0;
    int unsigned          cycle_count = 0;
    stall_mode_t          stall_mode = STALL_NONE;
    int                   stall_left = 0;

    crc32_frame_deframer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side stalls in randomly chosen modes: none, light, heavy or periodic.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE: result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall <= 1'($urandom_range(0, 1));
            default: result_stall <= ((stall_left % 5) < 2);
        endcase
    end

    // Every accepted result transfer is checked.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.match_result(result);
    end

    // Register read over the configuration port, compared with the expected value.
    task automatic reg_read_check(int idx, logic [31:0] want);
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            sb.flag($sformatf("register %0d read: expected %h, got %h", idx, want, got));
    endtask

    // Register write, mirrored into the predictor and read back.
    task automatic cfg_write(int idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_read_check(idx, value);
    endtask

    task automatic cfg_write_all(logic [15:0] max_len, logic [7:0] version,
                                 logic [7:0] first, logic [7:0] second);
        cfg_write(REG_MAX_BODY_LEN, {16'd0, max_len});
        cfg_write(REG_EXPECTED_VERSION, {24'd0, version});
        cfg_write(REG_MAGIC_FIRST, {24'd0, first});
        cfg_write(REG_MAGIC_SECOND, {24'd0, second});
    endtask

    // Queue one stream byte; a pending restart rides on it.
    function automatic void push_byte(logic [7:0] b);
        cfd_item_t it;
        it.data_byte = b;
        it.restart   = restart_next;
        restart_next = 1'b0;
        stream_q.push_back(it);
    endfunction

    function automatic void add_prefix(logic [31:0] value);
        for (int i = 3; i >= 0; i--)
            push_byte(value[8*i +: 8]);
    endfunction

    function automatic void add_noise(int count);
        for (int i = 0; i < count; i++)
            stream_q.push_back(cfd_item_t'(9'($urandom)));
        restart_next = 1'b1;
    endfunction

    // Build one frame for the current settings; a nonzero cut shorter than the
    // frame keeps only that many leading bytes and restarts the next transfer.
    function automatic void add_frame(int pay_len, int fill, int bad_magic,
                                      bit bad_ver, bit bad_crc, int cut);
        logic [7:0]  frame_bytes [$];
        logic [31:0] body_len;
        logic [31:0] crc;
        int          keep;
        body_len = HEADER_BYTES + pay_len;
        for (int i = 0; i < HEADER_BYTES + pay_len; i++)
        begin
            case (fill)
                FILL_ZERO: frame_bytes.push_back(8'h00);
                FILL_ONES: frame_bytes.push_back(8'hFF);
                default: frame_bytes.push_back(8'($urandom));
            endcase
        end
        frame_bytes[0] = sb.cfg.magic_first;
        frame_bytes[1] = sb.cfg.magic_second;
        frame_bytes[2] = sb.cfg.expected_version;
        if (bad_magic == MAGIC_BAD_FIRST || bad_magic == MAGIC_BAD_BOTH)
            frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
        if (bad_magic == MAGIC_BAD_SECOND || bad_magic == MAGIC_BAD_BOTH)
            frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 255));
        if (bad_ver)
            frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
        crc = CRC_INIT;
        foreach (frame_bytes[i])
            crc = crc32_advance(crc, frame_bytes[i]);
        crc = crc ^ CRC_INIT;
        if (bad_crc)
            crc = crc ^ (32'($urandom) | 32'd1 << $urandom_range(0, 31));
        // Length prefix in front, trailer behind, both big-endian.
        for (int i = 0; i < 4; i++)
            frame_bytes.push_front(body_len[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(crc[8*i +: 8]);
        keep = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
        for (int i = 0; i < keep; i++)
            push_byte(frame_bytes[i]);
        if (keep < frame_bytes.size())
            restart_next = 1'b1;
    endfunction

    // Sender pacing: bursts of random length with idle gaps between them.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                item       <= cfd_item_t'(9'($urandom));
            end
        end
        burst_left--;
    endtask

    task automatic send_item(cfd_item_t it);
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        sb.accept_byte(it);
        items_sent++;
    endtask

    task automatic drain_stream();
        while (stream_q.size() != 0)
        begin
            pace();
            send_item(stream_q.pop_front());
        end
    endtask

    // Stop sending, wait for every predicted result, then let the two-stage
    // pipeline empty.
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random traffic: mostly well-formed frames, plus errors, cuts and noise.
    task automatic run_random(int budget);
        int stop_at;
        int max_pay;
        int len;
        int pick;
        int fill;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            max_pay = int'(sb.cfg.max_body_len) - HEADER_BYTES;
            pick = $urandom_range(0, 15);
            if (pick == 0)
                len = (max_pay < 300) ? max_pay : 300;
            else if (pick == 1)
                len = $urandom_range(0, (max_pay < 300) ? max_pay : 300);
            else
                len = $urandom_range(0, (max_pay < 16) ? max_pay : 16);
            fill = ($urandom_range(0, 9) == 0) ? $urandom_range(FILL_ZERO, FILL_ONES)
                                               : FILL_RANDOM;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                add_frame(len, fill, MAGIC_OK, 1'b0, 1'b0, 0);
            else if (pick < 70)
                add_frame(len, fill, $urandom_range(MAGIC_OK, MAGIC_BAD_BOTH),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0);
            else if (pick < 80)
            begin
                case ($urandom_range(0, 3))
                    0: add_prefix($urandom_range(0, HEADER_BYTES - 1));
                    1: add_prefix(32'(sb.cfg.max_body_len) + 1 + $urandom_range(0, 40));
                    2: add_prefix({16'($urandom_range(1, 65535)), 16'($urandom)});
                    default: add_prefix($urandom);
                endcase
            end
            else if (pick < 92)
                add_frame(len, fill, MAGIC_OK, 1'b0, 1'b0,
                          $urandom_range(1, len + HEADER_BYTES + 7));
            else
                add_noise($urandom_range(1, 8));
            drain_stream();
        end
        settle();
    endtask

    initial
    begin
        // Reset, then check the register reset values.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        reg_read_check(REG_MAX_BODY_LEN, 32'd4096);
        reg_read_check(REG_EXPECTED_VERSION, 32'd1);
        reg_read_check(REG_MAGIC_FIRST, 32'd83);
        reg_read_check(REG_MAGIC_SECOND, 32'd78);

        // Directed frames under the reset settings.
        add_frame(0, FILL_RANDOM, MAGIC_OK, 1'b0, 1'b0, 0);
        add_frame(1, FILL_ZERO, MAGIC_OK, 1'b0, 1'b0, 0);
        add_frame(7, FILL_ONES, MAGIC_OK, 1'b0, 1'b0, 0);
        add_frame(3, FILL_RANDOM, MAGIC_OK, 1'b0, 1'b1, 0);
        add_frame(3, FILL_RANDOM, MAGIC_BAD_FIRST, 1'b0, 1'b0, 0);
        add_frame(3, FILL_RANDOM, MAGIC_BAD_SECOND, 1'b0, 1'b0, 0);
        add_frame(3, FILL_RANDOM, MAGIC_OK, 1'b1, 1'b0, 0);
        add_frame(2, FILL_RANDOM, MAGIC_BAD_BOTH, 1'b0, 1'b1, 0);
        add_frame(2, FILL_RANDOM, MAGIC_BAD_BOTH, 1'b1, 1'b0, 0);
        add_prefix(32'd31);
        add_prefix(32'd0);
        add_prefix(32'hFFFF_FFFF);
        add_prefix(32'd4097);
        add_prefix(32'h0001_0020);
        // Restarts that drop a frame in its prefix, header, payload and trailer.
        add_frame(5, FILL_RANDOM, MAGIC_OK, 1'b0, 1'b0, 2);
        add_frame(5, FILL_RANDOM, MAGIC_OK, 1'b0, 1'b0, 10);
        add_frame(10, FILL_RANDOM, MAGIC_OK, 1'b0, 1'b0, 40);
        add_frame(10, FILL_RANDOM, MAGIC_OK, 1'b0, 1'b0, 48);
        add_frame(4, FILL_RANDOM, MAGIC_OK, 1'b0, 1'b0, 0);
        drain_stream();
        settle();

        // Smallest body limit: only empty payloads pass.
        cfg_write_all(16'd32, 8'd0, 8'd0, 8'd0);
        run_random(25);

        // Largest body limit, then a prefix just past the body counter range.
        cfg_write_all(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(25);
        restart_next = 1'b1;
        add_prefix(32'h0001_0000);
        drain_stream();
        settle();

        // Random settings.
        repeat (2)
        begin
            cfg_write_all(16'($urandom_range(33, 400)), 8'($urandom), 8'($urandom),
                          8'($urandom));
            run_random(25);
        end

        // Back to the usual protocol values with a modest limit.
        cfg_write_all(16'd100, 8'd1, 8'd83, 8'd78);
        run_random(25);

        if (sb.pending_results.size() != 0)
            sb.flag($sformatf("%0d expected results never arrived",
                              sb.pending_results.size()));
        if (sb.mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/cfd_pkg.sv
src/cfd_regs.sv
src/crc32_frame_deframer_top.sv
tb/crc32_frame_deframer_top_tb.sv
